// ===== hdl/sbf_pkg.sv =====
// ----------------------------------------------------------------------------
// Slot bitmap package
// Widths, codes and shared types for the slot bitmap fill and clear block.
// ----------------------------------------------------------------------------
package sbf_pkg;

  localparam int WORD_BITS = 64;
  localparam int BIT_IDX_W = 6;
  localparam int SLOT_W    = 11;
  localparam int WIDX_W    = SLOT_W - BIT_IDX_W;
  localparam int POP_W     = BIT_IDX_W + 1;
  localparam int IDX_W     = 10;
  localparam int BYTE_W    = 3;

  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_NO_FREE = 1'b1;

  // Register index decoded from paddr[2]
  localparam logic REG_SLOTS_IN_USE = 1'b0;

  localparam logic [SLOT_W-1:0] SLOTS_IN_USE_RST = 11'd1024;

  typedef struct packed {
    logic [POP_W-1:0]     pop;
    logic                 any;
    logic [BIT_IDX_W-1:0] lo;
    logic [BIT_IDX_W-1:0] hi;
  } word_info_t;

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,
    S_IDLE = 6'b000010,
    S_READ = 6'b000100,
    S_EXEC = 6'b001000,
    S_FINE = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

endpackage

// ===== hdl/sbf_word_unit.sv =====
// ----------------------------------------------------------------------------
// Slot bitmap word unit
// Population count and lowest / highest set bit of one 64-bit bitmap word.
// ----------------------------------------------------------------------------
module sbf_word_unit (
  input  logic [sbf_pkg::WORD_BITS-1:0] vec_i,
  output sbf_pkg::word_info_t           info_o
);
  import sbf_pkg::*;

  logic [POP_W-1:0]     pop;
  logic [BIT_IDX_W-1:0] lo;
  logic [BIT_IDX_W-1:0] hi;

  always_comb begin
    pop = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      pop = pop + POP_W'(vec_i[i]);
    end
  end

  // Scanning downward leaves the lowest set bit.
  always_comb begin
    lo = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        lo = BIT_IDX_W'(i);
      end
    end
  end

  always_comb begin
    hi = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (vec_i[i]) begin
        hi = BIT_IDX_W'(i);
      end
    end
  end

  assign info_o.pop = pop;
  assign info_o.any = |vec_i;
  assign info_o.lo  = lo;
  assign info_o.hi  = hi;

endmodule

// ===== hdl/slot_bitmap_fill_and_clear.sv =====
// ----------------------------------------------------------------------------
// Slot bitmap fill and clear
// Occupancy bitmap with place and clear requests, walked one 64-slot word
// at a time through a shared population count and priority encode unit.
// ----------------------------------------------------------------------------
// Usage: a request item enters on in_*; in_tuser selects place (0) or clear
// (1). A place finds the first free slot at or after start_slot and marks up
// to place_count free slots, returning the first and last slot filled; a
// clear empties the inclusive range and returns how many were occupied.
// Exactly one result item leaves on out_*, with out_tuser set when a place
// had no free slot or nothing to place.
// Each request walks the 64-slot words of its range in turn, each with one memory
// read, then one update and write-back; a place that ends part way through a word
// finishes it a byte at a time. Entry and result take their own states, and
// trivial requests go straight from entry to result.
// in_tready is high only while the block is idle; one request is in flight.
// After reset the bitmap memory is swept to zero, one word per cycle, over all
// ceil(SLOTS/64) words (16 by default); no item is taken meanwhile.
// A result waits in the output register while out_tready is low; the next
// request may be taken then, but its result holds until the register frees.
// The slots_in_use register is written through the cfg_ APB port.
// ----------------------------------------------------------------------------
module slot_bitmap_fill_and_clear #(
  parameter int SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // start_slot[9:0], place_count[20:10], clear_end[30:21]
  input  logic [0:0]  in_tuser,   // op[0]
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // first_slot[9:0], last_slot[19:10], removed_count[30:20]
  output logic [0:0]  out_tuser,  // status[0]
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import sbf_pkg::*;

  localparam int NWORDS = (SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int NCAP   = (SLOTS > 2047) ? 2047 : SLOTS;

  // Configuration
  logic [SLOT_W-1:0] slots_in_use_r;
  logic [SLOT_W-1:0] n_act;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_SLOTS_IN_USE) ? 32'(slots_in_use_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_in_use_r <= SLOTS_IN_USE_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_SLOTS_IN_USE) begin
      slots_in_use_r <= cfg_pwdata[SLOT_W-1:0];
    end
  end

  assign n_act = (slots_in_use_r > SLOT_W'(NCAP)) ? SLOT_W'(NCAP) : slots_in_use_r;

  // Request fields
  logic              in_op;
  logic [SLOT_W-1:0] in_start;
  logic [SLOT_W-1:0] in_count;
  logic [SLOT_W-1:0] in_cend;
  logic [SLOT_W-1:0] clr_end;

  assign in_op    = in_tuser[0];
  assign in_start = SLOT_W'(in_tdata[9:0]);
  assign in_count = in_tdata[20:10];
  assign in_cend  = SLOT_W'(in_tdata[30:21]);
  assign clr_end  = (in_cend > n_act - 1'b1) ? n_act - 1'b1 : in_cend;

  // Control and working registers
  state_t                state_r, state_nxt;
  logic [AW-1:0]         sweep_r, sweep_nxt;
  logic                  op_r, op_nxt;
  logic [SLOT_W-1:0]     start_r, start_nxt;
  logic [SLOT_W-1:0]     hi_r, hi_nxt;
  logic [WIDX_W-1:0]     w_r, w_nxt;
  logic [SLOT_W-1:0]     rem_r, rem_nxt;
  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      first_r, first_nxt;
  logic [IDX_W-1:0]      last_r, last_nxt;
  logic [SLOT_W-1:0]     removed_r, removed_nxt;
  logic [BYTE_W-1:0]     byte_r, byte_nxt;
  logic [WORD_BITS-1:0]  avail_r, avail_nxt;
  logic [WORD_BITS-1:0]  wdata_r, wdata_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic [31:0]           out_data_r, out_data_nxt;
  logic                  out_user_r, out_user_nxt;

  // Memory
  logic [WORD_BITS-1:0]  mem [NWORDS];
  logic [WORD_BITS-1:0]  rdata_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [WORD_BITS-1:0]  mem_wdata;
  logic [AW-1:0]         word_addr;

  assign word_addr = AW'(w_r);

  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      rdata_r <= mem[word_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Shared word unit
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] range_mask;
  logic [WORD_BITS-1:0] unit_vec;
  word_info_t           info;

  assign lo_mask = (w_r == start_r[SLOT_W-1:BIT_IDX_W]) ?
                   ({WORD_BITS{1'b1}} << start_r[BIT_IDX_W-1:0]) : {WORD_BITS{1'b1}};
  assign hi_mask = (w_r == hi_r[SLOT_W-1:BIT_IDX_W]) ?
                   ({WORD_BITS{1'b1}} >> (BIT_IDX_W'(WORD_BITS - 1) - hi_r[BIT_IDX_W-1:0])) :
                   {WORD_BITS{1'b1}};
  assign range_mask = lo_mask & hi_mask;
  // Place looks at free slots in range, clear at occupied ones.
  assign unit_vec   = (op_r == OP_PLACE) ? (~rdata_r & range_mask) : (rdata_r & range_mask);

  sbf_word_unit u_word (
    .vec_i  (unit_vec),
    .info_o (info)
  );

  // One byte of a partly used word, for the end of a place
  logic [7:0]           fine_avail;
  logic [7:0]           fine_take;
  logic [SLOT_W-1:0]    fine_rem;
  logic [IDX_W-1:0]     fine_last;
  logic [SLOT_W-1:0]    fine_pos;

  assign fine_avail = avail_r[{byte_r, 3'b000} +: 8];

  always_comb begin
    fine_take = '0;
    fine_rem  = rem_r;
    fine_last = last_r;
    fine_pos  = '0;
    for (int j = 0; j < 8; j++) begin
      fine_pos = {w_r, byte_r, 3'(j)};
      if (fine_avail[j] && fine_rem != '0) begin
        fine_take[j] = 1'b1;
        fine_rem     = fine_rem - 1'b1;
        fine_last    = fine_pos[IDX_W-1:0];
      end
    end
  end

  logic            in_fire;
  logic            word_last;
  logic [SLOT_W-1:0] exec_pos_lo;
  logic [SLOT_W-1:0] exec_pos_hi;
  logic [SLOT_W-1:0] exec_rem;

  assign in_tready   = (state_r == S_IDLE);
  assign in_fire     = in_tvalid && in_tready;
  assign word_last   = (w_r == hi_r[SLOT_W-1:BIT_IDX_W]);
  assign exec_pos_lo = {w_r, info.lo};
  assign exec_pos_hi = {w_r, info.hi};
  assign exec_rem    = rem_r - SLOT_W'(info.pop);

  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    op_nxt        = op_r;
    start_nxt     = start_r;
    hi_nxt        = hi_r;
    w_nxt         = w_r;
    rem_nxt       = rem_r;
    found_nxt     = found_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    removed_nxt   = removed_r;
    byte_nxt      = byte_r;
    avail_nxt     = avail_r;
    wdata_nxt     = wdata_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    mem_we        = 1'b0;
    mem_waddr     = word_addr;
    mem_wdata     = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r;
        sweep_nxt = sweep_r + 1'b1;
        if (sweep_r == AW'(NWORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          op_nxt      = in_op;
          start_nxt   = in_start;
          rem_nxt     = in_count;
          w_nxt       = in_start[SLOT_W-1:BIT_IDX_W];
          found_nxt   = 1'b0;
          first_nxt   = '0;
          last_nxt    = '0;
          removed_nxt = '0;
          byte_nxt    = '0;
          if (in_op == OP_PLACE) begin
            hi_nxt = n_act - 1'b1;
            if (in_count == '0 || in_start >= n_act) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_READ;
            end
          end else begin
            hi_nxt = clr_end;
            if (n_act == '0 || in_start > clr_end) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_READ;
            end
          end
        end
      end
      S_READ: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (op_r == OP_PLACE) begin
          if (!found_r && info.any) begin
            found_nxt = 1'b1;
            first_nxt = exec_pos_lo[IDX_W-1:0];
          end
          if (SLOT_W'(info.pop) <= rem_r) begin
            mem_we    = 1'b1;
            mem_wdata = rdata_r | unit_vec;
            rem_nxt   = exec_rem;
            if (info.any) begin
              last_nxt = exec_pos_hi[IDX_W-1:0];
            end
            if (exec_rem == '0 || word_last) begin
              state_nxt = S_DONE;
            end else begin
              w_nxt     = w_r + 1'b1;
              state_nxt = S_READ;
            end
          end else begin
            // More free slots here than items left: finish a byte at a time.
            avail_nxt = unit_vec;
            wdata_nxt = rdata_r;
            byte_nxt  = '0;
            state_nxt = S_FINE;
          end
        end else begin
          mem_we      = 1'b1;
          mem_wdata   = rdata_r & ~range_mask;
          removed_nxt = removed_r + SLOT_W'(info.pop);
          if (word_last) begin
            state_nxt = S_DONE;
          end else begin
            w_nxt     = w_r + 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_FINE: begin
        wdata_nxt = wdata_r | (WORD_BITS'(fine_take) << {byte_r, 3'b000});
        rem_nxt   = fine_rem;
        last_nxt  = fine_last;
        byte_nxt  = byte_r + 1'b1;
        if (fine_rem == '0) begin
          mem_we    = 1'b1;
          mem_wdata = wdata_nxt;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = (op_r == OP_PLACE && !found_r) ? STATUS_NO_FREE : STATUS_DONE;
          out_data_nxt  = {1'b0, removed_r, last_r, first_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    start_r    <= start_nxt;
    hi_r       <= hi_nxt;
    w_r        <= w_nxt;
    rem_r      <= rem_nxt;
    found_r    <= found_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    removed_r  <= removed_nxt;
    byte_r     <= byte_nxt;
    avail_r    <= avail_nxt;
    wdata_r    <= wdata_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_user_r;

  // Assertions
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in flight");

  a_no_item_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INIT |-> !in_tready)
    else $error("request taken during the bitmap clearing sweep");

  a_fine_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FINE |-> rem_r != '0)
    else $error("partial-word fill entered with no items left");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> !mem_we)
    else $error("bitmap written in a read cycle");

  a_result_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == S_DONE)
    else $error("result shown without a finished request");

endmodule
